// File: hdl/dfs_pkg.sv
`timescale 1ns / 1ps
// Package for the delayed fade sequencer: widths, codes, state types and the
// divider request/status structs. No dependencies.
package dfs_pkg;

  localparam int TIME_BITS  = 24;
  localparam int LEVEL_BITS = 16;
  localparam int REM_BITS   = TIME_BITS + 1;
  localparam int ELAPSED_W  = 16;
  localparam int THRESH_W   = 16;
  localparam int CFG_DATA_W = TIME_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int DIVIDEND_W = TIME_BITS + LEVEL_BITS;
  localparam int DIV_CNT_W  = $clog2(LEVEL_BITS);

  localparam logic [LEVEL_BITS-1:0] LMAX    = {LEVEL_BITS{1'b1}};
  localparam logic [LEVEL_BITS-1:0] VIS_MIN = LEVEL_BITS'(7);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_DELAY     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_DELAY    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_DURATION  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_DURATION = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SOLID_THRESHOLD   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SHOWN     = CFG_IDX_W'(5);

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_FADE_IN  = 2'd1,
    MODE_FADE_OUT = 2'd2,
    MODE_RESTORE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_OUT        = 3'd0,
    PH_WAIT_IN    = 3'd1,
    PH_FADING_IN  = 3'd2,
    PH_IN         = 3'd3,
    PH_WAIT_OUT   = 3'd4,
    PH_FADING_OUT = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_FADE_IN  = 2'd1,
    EV_FADE_OUT = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_DIV,
    S_FIN,
    S_OUT
  } fsm_state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [TIME_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [LEVEL_BITS-1:0] quotient;
  } div_sts_t;

endpackage

// File: hdl/dfs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the delayed fade sequencer: the request
// channel and the result channel. Depends on dfs_pkg.
interface dfs_in_if;
  import dfs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [ELAPSED_W-1:0] elapsed;

  modport source (output valid, mode, elapsed, input ready);
  modport sink   (input valid, mode, elapsed, output ready);
endinterface

interface dfs_out_if;
  import dfs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;
  logic                  solid;
  logic                  shown;
  logic [1:0]            sound_event;
  logic [2:0]            phase;
  logic                  active;

  modport source (output valid, level, solid, shown, sound_event, phase, active,
                  input ready);
  modport sink   (input valid, level, solid, shown, sound_event, phase, active,
                  output ready);
endinterface

// File: hdl/delayed_fade_sequencer.sv
`timescale 1ns / 1ps
// Delayed fade sequencer top level. Depends on dfs_pkg, dfs_if and dfs_div.
//
// Six-phase fader: faded out, waiting before fade-in, fading in, faded in,
// waiting before fade-out, fading out. Every request on the item channel
// (a tick with elapsed time, a fade-in request, a fade-out request, or a
// restore to default) produces exactly one request on the result channel
// carrying the held level, the solid and shown flags, a sound event, the
// phase and the active flag. The block works on one request at a time.
// Requests, restores and ticks that do not ramp the level go from acceptance
// through the execute and output states to the result register. A tick that
// ramps the level also goes through the load, divide and write-back states,
// where the divider forms counter * (2^LEVEL_BITS-1) / duration one quotient
// bit per cycle. A finished result sits in an output register, so the next
// request is accepted while the result still waits to be taken; processing
// of that next request stalls only at its own result hand-off. Configuration
// writes are taken at any time but must only happen while the block is idle.
// A duration register of zero behaves as one.
module delayed_fade_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  dfs_in_if.sink                            item,
  dfs_out_if.source                         result,
  input  logic                              cfg_wen,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [dfs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import dfs_pkg::*;

  // Configuration registers.
  logic [TIME_BITS-1:0] fade_in_delay;
  logic [TIME_BITS-1:0] fade_out_delay;
  logic [TIME_BITS-1:0] fade_in_duration;
  logic [TIME_BITS-1:0] fade_out_duration;
  logic [THRESH_W-1:0]  solid_threshold;
  logic                 default_shown;

  // Sequencer state.
  fsm_state_t            state, state_next;
  phase_t                phase_reg, phase_reg_next;
  logic [REM_BITS-1:0]   remaining, remaining_next;
  logic                  last_request_in, last_request_in_next;
  logic [LEVEL_BITS-1:0] level_reg, level_reg_next;
  logic                  solid_reg, solid_reg_next;
  logic                  shown_reg, shown_reg_next;
  event_t                ev, ev_next;

  // Captured request.
  mode_t                 mode_q;
  logic [ELAPSED_W-1:0]  elapsed_q;

  // Datapath helpers.
  logic                  dur_in_sel;
  logic [TIME_BITS-1:0]  dur_eff;
  logic [REM_BITS-1:0]   rem_sub;
  logic [TIME_BITS-1:0]  clamped;
  logic                  fading_in;
  logic [LEVEL_BITS-1:0] new_level;
  logic                  out_load;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  div_req_t              div_req;
  div_sts_t              div_sts;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_in_delay     <= '0;
      fade_out_delay    <= '0;
      fade_in_duration  <= TIME_BITS'(1);
      fade_out_duration <= TIME_BITS'(1);
      solid_threshold   <= THRESH_W'(32768);
      default_shown     <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        REG_FADE_IN_DELAY:     fade_in_delay     <= cfg_wdata[TIME_BITS-1:0];
        REG_FADE_OUT_DELAY:    fade_out_delay    <= cfg_wdata[TIME_BITS-1:0];
        REG_FADE_IN_DURATION:  fade_in_duration  <= cfg_wdata[TIME_BITS-1:0];
        REG_FADE_OUT_DURATION: fade_out_duration <= cfg_wdata[TIME_BITS-1:0];
        REG_SOLID_THRESHOLD:   solid_threshold   <= cfg_wdata[THRESH_W-1:0];
        REG_DEFAULT_SHOWN:     default_shown     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The fade-in duration serves both the wait before fade-in (where the
  // leftover time is carried into the ramp) and the fade-in ramp itself.
  assign dur_in_sel = (phase_reg == PH_WAIT_IN) || (phase_reg == PH_FADING_IN);
  always_comb begin
    dur_eff = dur_in_sel ? fade_in_duration : fade_out_duration;
    if (dur_eff == '0) begin
      dur_eff = TIME_BITS'(1);
    end
  end

  assign rem_sub   = remaining - {{(REM_BITS - ELAPSED_W){1'b0}}, elapsed_q};
  assign fading_in = (phase_reg == PH_FADING_IN);

  // Counter clamped to [0, duration]. A non-negative remaining value always
  // fits in TIME_BITS, so the sign bit alone marks the low clamp.
  always_comb begin
    if (remaining[REM_BITS-1]) begin
      clamped = '0;
    end else if (remaining[TIME_BITS-1:0] > dur_eff) begin
      clamped = dur_eff;
    end else begin
      clamped = remaining[TIME_BITS-1:0];
    end
  end

  // Dividend is clamped * LMAX, formed as a shift and one subtraction.
  assign div_dividend = {clamped, {LEVEL_BITS{1'b0}}}
                      - {{LEVEL_BITS{1'b0}}, clamped};
  assign div_req      = {div_start, div_dividend, dur_eff};

  assign new_level = fading_in ? (LMAX - div_sts.quotient) : div_sts.quotient;

  dfs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .sts (div_sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase_reg       <= PH_OUT;
      remaining       <= '0;
      last_request_in <= 1'b0;
      level_reg       <= '0;
      solid_reg       <= 1'b0;
      shown_reg       <= 1'b0;
      ev              <= EV_NONE;
    end else begin
      state           <= state_next;
      phase_reg       <= phase_reg_next;
      remaining       <= remaining_next;
      last_request_in <= last_request_in_next;
      level_reg       <= level_reg_next;
      solid_reg       <= solid_reg_next;
      shown_reg       <= shown_reg_next;
      ev              <= ev_next;
    end
  end

  // Capture the request payload when it is accepted.
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      mode_q    <= mode_t'(item.mode);
      elapsed_q <= item.elapsed;
    end
  end

  assign item.ready = (state == S_IDLE);

  always_comb begin
    state_next           = state;
    phase_reg_next       = phase_reg;
    remaining_next       = remaining;
    last_request_in_next = last_request_in;
    level_reg_next       = level_reg;
    solid_reg_next       = solid_reg;
    shown_reg_next       = shown_reg;
    ev_next              = ev;
    div_start            = 1'b0;
    out_load             = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (item.valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        ev_next    = EV_NONE;
        state_next = S_OUT;
        unique case (mode_q)
          MODE_TICK: begin
            if (phase_reg == PH_WAIT_IN || phase_reg == PH_WAIT_OUT) begin
              if (rem_sub[REM_BITS-1]) begin
                // Delay expired: start the ramp at the full duration and
                // take off the overshoot right away.
                remaining_next = {1'b0, dur_eff} + rem_sub;
                phase_reg_next = dur_in_sel ? PH_FADING_IN : PH_FADING_OUT;
                ev_next        = dur_in_sel ? EV_FADE_IN : EV_FADE_OUT;
                state_next     = S_LOAD;
              end else begin
                remaining_next = rem_sub;
              end
            end else if (phase_reg == PH_FADING_IN || phase_reg == PH_FADING_OUT) begin
              remaining_next = rem_sub;
              state_next     = S_LOAD;
            end
          end
          MODE_FADE_IN: begin
            last_request_in_next = 1'b1;
            if (phase_reg == PH_OUT) begin
              remaining_next = {1'b0, fade_in_delay};
              phase_reg_next = PH_WAIT_IN;
            end
          end
          MODE_FADE_OUT: begin
            last_request_in_next = 1'b0;
            if (phase_reg == PH_IN) begin
              remaining_next = {1'b0, fade_out_delay};
              phase_reg_next = PH_WAIT_OUT;
            end
          end
          MODE_RESTORE: begin
            phase_reg_next       = default_shown ? PH_IN : PH_OUT;
            solid_reg_next       = default_shown;
            shown_reg_next       = default_shown;
            last_request_in_next = default_shown;
          end
        endcase
      end

      S_LOAD: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end

      S_DIV: begin
        if (div_sts.done) begin
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        level_reg_next = new_level;
        solid_reg_next = new_level > solid_threshold;
        shown_reg_next = new_level >= VIS_MIN;
        if (remaining[REM_BITS-1]) begin
          // Ramp finished. If the latched request points the other way, the
          // opposite delay starts at once.
          phase_reg_next = fading_in ? PH_IN : PH_OUT;
          if (fading_in != last_request_in) begin
            phase_reg_next = last_request_in ? PH_WAIT_IN : PH_WAIT_OUT;
            remaining_next = last_request_in ? {1'b0, fade_in_delay}
                                             : {1'b0, fade_out_delay};
          end
        end
        state_next = S_OUT;
      end

      S_OUT: begin
        if (!result.valid || result.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Output register: holds one result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.level       <= level_reg;
      result.solid       <= solid_reg;
      result.shown       <= shown_reg;
      result.sound_event <= ev;
      result.phase       <= phase_reg;
      result.active      <= (phase_reg == PH_WAIT_IN) || (phase_reg == PH_FADING_IN)
                         || (phase_reg == PH_WAIT_OUT) || (phase_reg == PH_FADING_OUT);
    end
  end

  // The divider only reports completion while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> state == S_DIV)
    else $error("divider finished outside the divide wait");

  // A division is only started for a ramping phase.
  a_load_in_fade: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> (phase_reg == PH_FADING_IN || phase_reg == PH_FADING_OUT))
    else $error("level computation started outside a fade");

  // The held level only changes when a division result is written back.
  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_FIN |=> $stable(level_reg))
    else $error("level changed outside the write-back step");

endmodule

// File: hdl/dfs_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on dfs_pkg. The caller guarantees the quotient fits in LEVEL_BITS.
module dfs_div (
  input  logic              clk,
  input  logic              rst,
  input  dfs_pkg::div_req_t req,
  output dfs_pkg::div_sts_t sts
);
  import dfs_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [TIME_BITS-1:0]  rem;
  logic [LEVEL_BITS-1:0] low;
  logic [TIME_BITS-1:0]  divisor;
  logic [TIME_BITS:0]    trial;
  logic [TIME_BITS:0]    diff;
  logic                  qbit;
  logic [TIME_BITS-1:0]  rem_next;

  // Bring down the next dividend bit and try one subtraction.
  assign trial    = {rem, low[LEVEL_BITS-1]};
  assign diff     = trial - {1'b0, divisor};
  assign qbit     = !diff[TIME_BITS];
  assign rem_next = qbit ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(LEVEL_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend's low bits shift out as the quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.dividend[DIVIDEND_W-1:LEVEL_BITS];
      low     <= req.dividend[LEVEL_BITS-1:0];
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      low <= {low[LEVEL_BITS-2:0], qbit};
    end
  end

  assign sts = {done, low};

endmodule
